FILE: sv/bve_pkg.sv
// bve_pkg: shared types and codes of the bounded vector engine.
// Beat structs for both channels, operation codes, cell modes, sequencer states.
// No dependencies.
package bve_pkg;

    // Operation codes carried in the func field
    typedef enum logic [3:0] {
        FN_PUSH_BACK   = 4'd0,
        FN_POP_BACK    = 4'd1,
        FN_PUSH_FRONT  = 4'd2,
        FN_POP_FRONT   = 4'd3,
        FN_ERASE_VALUE = 4'd4,
        FN_ERASE_AT    = 4'd5,
        FN_FIND        = 4'd6,
        FN_READ_AT     = 4'd7,
        FN_CLEAR       = 4'd8
    } func_e;

    // Request beat
    typedef struct packed {
        logic [3:0]  func;
        logic [31:0] value;
        logic [6:0]  position;
    } req_beat_t;

    // Response beat
    typedef struct packed {
        logic        ok;
        logic [7:0]  index;
        logic [31:0] data;
        logic [7:0]  count;
        logic [7:0]  removed;
    } rsp_beat_t;

    // What every cell of the chain does in a cycle
    typedef enum logic [2:0] {
        CM_HOLD,     // keep contents
        CM_WRITE,    // selected cell loads the broadcast value
        CM_INSERT,   // all cells take left neighbor, cell 0 loads broadcast
        CM_REMOVE,   // cells at or above the selected position take right neighbor
        CM_ROTATE,   // all cells take right neighbor, last takes cell 0
        CM_COMPACT   // all take right neighbor, selected cell loads broadcast if wen
    } cell_mode_e;

    typedef struct packed {
        cell_mode_e mode;
        logic       wen;
    } cell_ctl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_e;

endpackage

FILE: sv/bve_cell.sv
// bve_cell: one storage cell of the element chain.
// Holds one element and trades it with its neighbors under a broadcast command.
// Depends on bve_pkg.
module bve_cell #(
    parameter int ELEM_WIDTH = 32,
    parameter int IDX_W      = 7,
    parameter int CELL_IDX   = 0
) (
    input  logic                   clk,
    input  bve_pkg::cell_ctl_t     ctl,
    input  logic [IDX_W-1:0]       sel_pos,
    input  logic [ELEM_WIDTH-1:0]  bval,
    input  logic [ELEM_WIDTH-1:0]  left,
    input  logic [ELEM_WIDTH-1:0]  right,
    output logic [ELEM_WIDTH-1:0]  q
);
    import bve_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;

    // next element from the command and the position compare
    always_comb
    begin
        data_next = data_reg;
        case (ctl.mode)
            CM_HOLD:    data_next = data_reg;
            CM_WRITE:   data_next = (sel_pos == MY_IDX) ? bval : data_reg;
            CM_INSERT:  data_next = (CELL_IDX == 0) ? bval : left;
            CM_REMOVE:  data_next = (MY_IDX >= sel_pos) ? right : data_reg;
            CM_ROTATE:  data_next = right;
            CM_COMPACT: data_next = (ctl.wen && (sel_pos == MY_IDX)) ? bval : right;
            default:    data_next = data_reg;
        endcase
    end

    // element storage, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

FILE: sv/bounded_vector_engine_unit.sv
// bounded_vector_engine_unit: fixed-capacity packed list built as a chain of cells.
// Depends on bve_pkg and bve_cell.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation per beat;
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result beat each.
//   One operation is in work at a time; a new request is taken as soon as the
//   previous one has placed its result, even while that result waits in the
//   output register.
// Work after a request is accepted:
//   push, pop, erase_at, clear, out-of-range read, find on an empty list,
//     unknown code: straight to the result, with no scan.
//   erase_value: a scan that examines each element once, one head element per
//     cycle while the chain shifts and survivors are rewritten in place.
//   find on a non-empty list, in-range read_at: a scan over a full rotation
//     of the chain so every cell returns to its place.
// Reset: the count goes to zero, no result is pending; element cells are not
//   cleared, only entries below the count are ever read.
// Receiver stall: the result stays in the output register; one further request
//   is taken and worked, then waits until the register drains.
module bounded_vector_engine_unit #(
    parameter int CAPACITY   = 128,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  bve_pkg::req_beat_t   req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output bve_pkg::rsp_beat_t   rsp
);
    import bve_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // cell chain
    cell_ctl_t             cell_ctl;
    logic [IDX_W-1:0]      sel_pos;
    logic [ELEM_WIDTH-1:0] bval;
    logic [ELEM_WIDTH-1:0] q [CAPACITY];
    logic [ELEM_WIDTH-1:0] head;

    assign head = q[0];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ELEM_WIDTH-1:0] left_w;
        logic [ELEM_WIDTH-1:0] right_w;
        if (i == 0)
        begin : g_first
            assign left_w = bval;
        end
        else
        begin : g_mid_l
            assign left_w = q[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = q[0];
        end
        else
        begin : g_mid_r
            assign right_w = q[i+1];
        end
        bve_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_IDX   (i)
        ) u_cell (
            .clk     (clk),
            .ctl     (cell_ctl),
            .sel_pos (sel_pos),
            .bval    (bval),
            .left    (left_w),
            .right   (right_w),
            .q       (q[i])
        );
    end

    // sequencer registers
    state_e                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_beat_t             out_reg, out_next;
    rsp_beat_t             res_reg, res_next;
    func_e                 op_reg, op_next;
    logic [ELEM_WIDTH-1:0] val_reg, val_next;
    logic [6:0]            pos_reg, pos_next;
    logic [IDX_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]      kept_reg, kept_next;
    logic [CNT_W-1:0]      hits_reg, hits_next;

    logic [ELEM_WIDTH-1:0] req_val;
    logic                  full;
    logic                  pos_ok;
    logic                  head_hit;
    logic [CNT_W-1:0]      step_ext;
    logic [CNT_W-1:0]      wpos;

    assign req_val  = ELEM_WIDTH'(req.value);
    assign full     = (count_reg == FULL_CNT);
    assign pos_ok   = (CMP_W'(req.position) < CMP_W'(count_reg));
    assign head_hit = (head == val_reg);
    assign step_ext = CNT_W'(step_reg);
    // survivor with rank kept lands at kept after the remaining shifts
    assign wpos     = CNT_W'(kept_reg + count_reg - CNT_W'(1) - step_ext);

    // next state, cell command and result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        res_next       = res_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        kept_next      = kept_reg;
        hits_next      = hits_reg;
        cell_ctl       = '{mode: CM_HOLD, wen: 1'b0};
        sel_pos        = '0;
        bval           = req_val;
        req_ready      = 1'b0;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = func_e'(req.func);
                    val_next   = req_val;
                    pos_next   = req.position;
                    step_next  = '0;
                    kept_next  = '0;
                    hits_next  = '0;
                    res_next   = '0;
                    state_next = ST_EMIT;
                    case (req.func)
                        FN_PUSH_BACK:
                        begin
                            res_next.index = 8'(count_reg);
                            if (!full)
                            begin
                                cell_ctl.mode = CM_WRITE;
                                sel_pos       = count_reg[IDX_W-1:0];
                                count_next    = count_reg + CNT_W'(1);
                                res_next.ok   = 1'b1;
                            end
                        end
                        FN_POP_BACK:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next  = count_reg - CNT_W'(1);
                                res_next.ok = 1'b1;
                            end
                        end
                        FN_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_next.index = 8'(count_reg);
                            end
                            else
                            begin
                                cell_ctl.mode = CM_INSERT;
                                count_next    = count_reg + CNT_W'(1);
                                res_next.ok   = 1'b1;
                            end
                        end
                        FN_POP_FRONT:
                        begin
                            if (count_reg != '0)
                            begin
                                cell_ctl.mode = CM_REMOVE;
                                sel_pos       = '0;
                                count_next    = count_reg - CNT_W'(1);
                                res_next.ok   = 1'b1;
                            end
                        end
                        FN_ERASE_VALUE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        FN_ERASE_AT:
                        begin
                            if (pos_ok)
                            begin
                                cell_ctl.mode = CM_REMOVE;
                                sel_pos       = IDX_W'(req.position);
                                count_next    = count_reg - CNT_W'(1);
                                res_next.ok   = 1'b1;
                            end
                        end
                        FN_FIND:
                        begin
                            res_next.index = 8'(count_reg);
                            if (count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        FN_READ_AT:
                        begin
                            if (pos_ok)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        FN_CLEAR:
                        begin
                            count_next  = '0;
                            res_next.ok = 1'b1;
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                bval = head;
                case (op_reg)
                    FN_ERASE_VALUE:
                    begin
                        // consume head, rewrite it at its packed slot if kept
                        cell_ctl = '{mode: CM_COMPACT, wen: !head_hit};
                        sel_pos  = wpos[IDX_W-1:0];
                        if (head_hit)
                        begin
                            hits_next = hits_reg + CNT_W'(1);
                        end
                        else
                        begin
                            kept_next = kept_reg + CNT_W'(1);
                        end
                        step_next = step_reg + IDX_W'(1);
                        if (step_ext == count_reg - CNT_W'(1))
                        begin
                            count_next       = kept_next;
                            res_next.removed = 8'(hits_next);
                            res_next.ok      = (hits_next != '0);
                            state_next       = ST_EMIT;
                        end
                    end
                    FN_FIND:
                    begin
                        cell_ctl.mode = CM_ROTATE;
                        if ((step_ext < count_reg) && !res_reg.ok && head_hit)
                        begin
                            res_next.ok    = 1'b1;
                            res_next.index = 8'(step_reg);
                        end
                        step_next = step_reg + IDX_W'(1);
                        if (step_reg == LAST_IDX)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    default:
                    begin
                        // read_at: capture the element as it passes cell 0
                        cell_ctl.mode = CM_ROTATE;
                        if (CMP_W'(step_reg) == CMP_W'(pos_reg))
                        begin
                            res_next.ok   = 1'b1;
                            res_next.data = 32'(head);
                        end
                        step_next = step_reg + IDX_W'(1);
                        if (step_reg == LAST_IDX)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                endcase
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_next.count = 8'(count_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            kept_reg      <= '0;
            hits_reg      <= '0;
            op_reg        <= FN_CLEAR;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            kept_reg      <= kept_next;
            hits_reg      <= hits_next;
            op_reg        <= op_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        res_reg <= res_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("element count above capacity");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.func == FN_PUSH_BACK) && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push at the back did not grow the list");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && (!out_valid_reg || rsp_ready))
        |=> (rsp_valid && (rsp.count == 8'($past(count_reg)))))
        else $error("result count differs from list count");

    a_compact_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (op_reg == FN_ERASE_VALUE)) |-> (count_reg != '0))
        else $error("compaction running on an empty list");

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for bounded_vector_engine_unit; predicts each result beat
// from a shadow copy of the list and compares it field by field with the DUT.
// Depends on bve_pkg and the bounded_vector_engine_unit RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bve_pkg::*;

    localparam int CAP         = 128;
    localparam int POS_MAX     = 127;
    localparam int FUNC_MAX    = 15;
    localparam int N_ITEMS     = 650;
    localparam int TAIL_ITEMS  = 60;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AT     = 300;
    localparam int CYCLE_LIMIT = 600000;

    // Operation mixes used by the random phases
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_QUERY  = 2;
    localparam int MIX_ANY    = 3;

    typedef struct {
        req_beat_t beat;
        bit        drain_first;   // sender waits for every result before offering
    } queued_op_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_beat_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_beat_t rsp;

    // Shadow list and bookkeeping
    logic [31:0]  list_elems [CAP];
    int           list_len;
    logic [31:0]  value_pool [8];
    queued_op_t   op_backlog [$];
    rsp_beat_t    due_results [$];
    int unsigned  req_sent_q;
    int unsigned  rsp_seen_q;
    int unsigned  tail_start;
    int unsigned  fail_cnt;
    int unsigned  cycle_cnt;
    int unsigned  gap_left;
    int unsigned  stall_left;
    int unsigned  hold_left;
    bit           hold_done;

    bounded_vector_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Close the gap left by removing the element at pos
    function automatic void drop_elem(int pos);
        for (int k = pos + 1; k < list_len; k++)
            list_elems[k - 1] = list_elems[k];
        list_len--;
    endfunction

    // Apply one operation to the shadow list and return the result beat it gives
    function automatic rsp_beat_t apply_list_op(req_beat_t op);
        rsp_beat_t r;
        int        hits;
        r = '0;
        case (op.func)
            FN_PUSH_BACK:
            begin
                r.index = 8'(list_len);
                if (list_len < CAP)
                begin
                    list_elems[list_len] = op.value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            FN_POP_BACK:
            begin
                if (list_len > 0)
                begin
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            FN_PUSH_FRONT:
            begin
                if (list_len >= CAP)
                    r.index = 8'(list_len);
                else
                begin
                    for (int k = list_len; k > 0; k--)
                        list_elems[k] = list_elems[k - 1];
                    list_elems[0] = op.value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            FN_POP_FRONT:
            begin
                if (list_len > 0)
                begin
                    drop_elem(0);
                    r.ok = 1'b1;
                end
            end
            FN_ERASE_VALUE:
            begin
                // survivors slide down over the removed matches
                hits = 0;
                for (int k = 0; k < list_len; k++)
                begin
                    if (list_elems[k] == op.value)
                        hits++;
                    else if (hits > 0)
                        list_elems[k - hits] = list_elems[k];
                end
                list_len -= hits;
                r.removed = 8'(hits);
                r.ok = (hits > 0);
            end
            FN_ERASE_AT:
            begin
                if (int'(op.position) < list_len)
                begin
                    drop_elem(int'(op.position));
                    r.ok = 1'b1;
                end
            end
            FN_FIND:
            begin
                r.index = 8'(list_len);
                for (int k = 0; k < list_len; k++)
                begin
                    if (list_elems[k] == op.value)
                    begin
                        r.index = 8'(k);
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
            FN_READ_AT:
            begin
                if (int'(op.position) < list_len)
                begin
                    r.data = list_elems[op.position];
                    r.ok = 1'b1;
                end
            end
            FN_CLEAR:
            begin
                list_len = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = 8'(list_len);
        return r;
    endfunction

    // Queue one beat for the driver; the shadow list tracks the state while building
    task automatic queue_op(logic [3:0] fn, logic [31:0] v, logic [6:0] p, bit drain);
        queued_op_t q;
        q.beat.func     = fn;
        q.beat.value    = v;
        q.beat.position = p;
        q.drain_first   = drain;
        op_backlog.insert(op_backlog.size(), q);
        void'(apply_list_op(q.beat));
    endtask

    // Operand value: often one already stored, so finds and erases hit
    function automatic logic [31:0] pick_value(bit from_list);
        if (from_list && list_len > 0 && $urandom_range(0, 1) == 0)
            return list_elems[$urandom_range(0, list_len - 1)];
        if ($urandom_range(0, 4) < 3)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Mostly in range, sometimes anywhere in the field
    function automatic logic [6:0] pick_position();
        if (list_len > 0 && $urandom_range(0, 4) != 0)
            return 7'($urandom_range(0, list_len - 1));
        return 7'($urandom_range(0, POS_MAX));
    endfunction

    // Draw an operation code from the weights of one mix; last slot is an unused code
    function automatic logic [3:0] pick_func(int mix);
        int wt [10];
        int r;
        case (mix)
            MIX_GROW:   wt = '{30, 4, 25, 4, 4, 4, 10, 15, 0, 4};
            MIX_SHRINK: wt = '{8, 20, 5, 20, 15, 15, 7, 7, 0, 3};
            MIX_QUERY:  wt = '{12, 4, 8, 4, 10, 5, 27, 27, 0, 3};
            default:    wt = '{14, 10, 12, 10, 10, 10, 12, 14, 2, 6};
        endcase
        r = $urandom_range(0, 99);
        for (int i = 0; i < 9; i++)
        begin
            if (r < wt[i])
                return 4'(i);
            r -= wt[i];
        end
        return 4'($urandom_range(int'(FN_CLEAR) + 1, FUNC_MAX));
    endfunction

    task automatic build_directed();
        logic [3:0] unused_lo;
        unused_lo = 4'(int'(FN_CLEAR) + 1);
        // pops, erases, read and find on an empty list
        queue_op(FN_POP_BACK,    '0, '0, 1'b0);
        queue_op(FN_POP_FRONT,   '0, '0, 1'b0);
        queue_op(FN_ERASE_AT,    '0, '0, 1'b0);
        queue_op(FN_READ_AT,     '0, '0, 1'b0);
        queue_op(FN_FIND,        '0, '0, 1'b0);
        queue_op(FN_ERASE_VALUE, '0, '0, 1'b0);
        // a few pushes with extreme and repeated values
        queue_op(FN_PUSH_BACK,   32'h0000_0000, '0, 1'b0);
        queue_op(FN_PUSH_BACK,   32'hFFFF_FFFF, '0, 1'b0);
        queue_op(FN_PUSH_FRONT,  32'hA5A5_A5A5, '0, 1'b0);
        queue_op(FN_PUSH_FRONT,  32'h0000_0000, '0, 1'b0);
        queue_op(FN_PUSH_BACK,   32'h0000_0000, '0, 1'b0);
        // searches: hit late, hit first, miss
        queue_op(FN_FIND,        32'hFFFF_FFFF, '0, 1'b0);
        queue_op(FN_FIND,        32'h0000_0000, '0, 1'b0);
        queue_op(FN_FIND,        32'h1234_5678, '0, 1'b0);
        // reads at both ends, at the count and at the top of the field
        queue_op(FN_READ_AT,     '0, 7'd0, 1'b0);
        queue_op(FN_READ_AT,     '0, 7'(list_len - 1), 1'b0);
        queue_op(FN_READ_AT,     '0, 7'(list_len), 1'b0);
        queue_op(FN_READ_AT,     '0, 7'(POS_MAX), 1'b0);
        queue_op(FN_ERASE_AT,    '0, 7'd1, 1'b0);
        queue_op(FN_ERASE_AT,    '0, 7'(POS_MAX), 1'b0);
        // several matches removed at once
        queue_op(FN_ERASE_VALUE, 32'h0000_0000, '0, 1'b0);
        queue_op(unused_lo,      32'hFFFF_FFFF, 7'(POS_MAX), 1'b0);
        queue_op(4'(FUNC_MAX),   32'hFFFF_FFFF, 7'(POS_MAX), 1'b0);
        queue_op(FN_PUSH_BACK,   32'h8000_0001, '0, 1'b0);
        queue_op(FN_POP_BACK,    '0, '0, 1'b0);
        queue_op(FN_CLEAR,       '0, '0, 1'b0);
        queue_op(FN_CLEAR,       '0, '0, 1'b0);
    endtask

    task automatic build_random();
        int         phase_no;
        int         span;
        int         mix;
        bit         drain;
        logic [3:0] fn;
        phase_no = 0;
        while (op_backlog.size() < N_ITEMS)
        begin
            value_pool[0] = 32'h0000_0000;
            value_pool[1] = 32'hFFFF_FFFF;
            for (int i = 2; i < 8; i++)
                value_pool[i] = $urandom;
            drain = 1'b1;
            if (phase_no % 4 == 0)
            begin
                // fill to capacity, then refused pushes and work on a full list
                while (list_len < CAP)
                begin
                    fn = ($urandom_range(0, 1) != 0) ? FN_PUSH_BACK : FN_PUSH_FRONT;
                    queue_op(fn, pick_value(1'b0), 7'($urandom), drain);
                    drain = 1'b0;
                end
                queue_op(FN_PUSH_BACK,  $urandom, 7'($urandom), 1'b0);
                queue_op(FN_PUSH_FRONT, $urandom, 7'($urandom), 1'b0);
                queue_op(FN_READ_AT,    $urandom, 7'(POS_MAX), 1'b0);
                queue_op(FN_FIND,       pick_value(1'b1), 7'($urandom), 1'b0);
                queue_op(FN_ERASE_AT,   $urandom, pick_position(), 1'b0);
                queue_op(FN_ERASE_VALUE, pick_value(1'b1), 7'($urandom), 1'b0);
            end
            else
            begin
                mix = $urandom_range(MIX_GROW, MIX_ANY);
                span = $urandom_range(30, 90);
                for (int i = 0; i < span; i++)
                begin
                    fn = pick_func(mix);
                    case (fn)
                        FN_PUSH_BACK, FN_PUSH_FRONT:
                            queue_op(fn, pick_value(1'b0), 7'($urandom), drain);
                        FN_FIND, FN_ERASE_VALUE:
                            queue_op(fn, pick_value(1'b1), 7'($urandom), drain);
                        FN_ERASE_AT, FN_READ_AT:
                            queue_op(fn, $urandom, pick_position(), drain);
                        default:
                            queue_op(fn, $urandom, 7'($urandom), drain);
                    endcase
                    drain = 1'b0;
                end
            end
            phase_no++;
        end
    endtask

    // Driver: offers queued beats, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        bit          fire;
        bit          offer;
        int unsigned sent_now;
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req        <= '0;
            req_sent_q <= 0;
            gap_left   = 0;
        end
        else
        begin
            fire = req_valid && req_ready;
            sent_now = req_sent_q;
            if (fire)
            begin
                due_results.insert(due_results.size(), apply_list_op(req));
                sent_now++;
                req_sent_q <= sent_now;
                if (sent_now < tail_start && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 10);
            end
            offer = req_valid && !fire;
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (op_backlog.size() > 0 &&
                         (!op_backlog[0].drain_first || sent_now == rsp_seen_q))
                begin
                    req <= op_backlog[0].beat;
                    op_backlog.delete(0);
                    offer = 1'b1;
                end
            end
            req_valid <= offer;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // Monitor: checks result beats and throttles rsp_ready
    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t want;
        if (!rst_n)
        begin
            rsp_ready  <= 1'b0;
            rsp_seen_q <= 0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_seen_q <= rsp_seen_q + 1;
                if (due_results.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    fail_cnt++;
                end
                else
                begin
                    want = due_results[0];
                    due_results.delete(0);
                    check_field("ok",      32'(want.ok),      32'(rsp.ok));
                    check_field("index",   32'(want.index),   32'(rsp.index));
                    check_field("data",    want.data,         rsp.data);
                    check_field("count",   32'(want.count),   32'(rsp.count));
                    check_field("removed", 32'(want.removed), 32'(rsp.removed));
                end
            end
            // one long hold-off mid-run so the engine backs up into the request side
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (!hold_done && req_sent_q >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                rsp_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (req_sent_q < tail_start && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("bounded_vector_engine_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        fail_cnt  = 0;
        cycle_cnt = 0;
        list_len  = 0;
        value_pool = '{default: '0};
        build_directed();
        build_random();
        tail_start = op_backlog.size() - TAIL_ITEMS;
        // shadow list restarts empty for the real run
        list_len = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (op_backlog.size() != 0 || req_valid)
            @(posedge clk);
        while (rsp_seen_q != req_sent_q)
            @(posedge clk);
        // catch any stray beat after the last expected one
        repeat (2 * CAP) @(posedge clk);
        if (fail_cnt == 0 && due_results.size() == 0)
            $display("bounded_vector_engine_unit verification clean");
        else
            $display("bounded_vector_engine_unit verification failed");
        $finish;
    end

endmodule
